// File: design/rc48_pkg.sv
package rc48_pkg;

    // default ring history depth
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 6;
    localparam int CODE_N  = 64;

    // value bits that must be clear for an id0 code
    localparam logic [VALUE_W-1:0] ID0_MASK = 6'h3C;

    // 4-of-8 line codes, indexed by the 6-bit value they carry
    localparam logic [BYTE_W-1:0] CODE_TABLE [CODE_N] = '{
        8'hAC, 8'hAA, 8'hA9, 8'hA5, 8'hA3, 8'hA6, 8'h9C, 8'h9A,
        8'h99, 8'h95, 8'h93, 8'h96, 8'h8E, 8'h8D, 8'h8B, 8'hB1,
        8'hB2, 8'hB4, 8'hB8, 8'h74, 8'h72, 8'h6C, 8'h6A, 8'h69,
        8'h65, 8'h63, 8'h66, 8'h5C, 8'h5A, 8'h59, 8'h55, 8'h53,
        8'h56, 8'h4E, 8'h4D, 8'h4B, 8'h47, 8'h71, 8'hE8, 8'hE4,
        8'hE2, 8'hD1, 8'hC9, 8'hC5, 8'hD8, 8'hD4, 8'hD2, 8'hCA,
        8'hC6, 8'hCC, 8'h78, 8'h17, 8'h1B, 8'h1D, 8'h1E, 8'h2E,
        8'h36, 8'h3A, 8'h27, 8'h2B, 8'h2D, 8'h35, 8'h39, 8'h33
    };

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } t_decode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OLD,
        ST_NEW,
        ST_DUMP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic handle;
        logic sel_new;
        logic dump_start;
        logic load_entry;
        logic load_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic dump_hit;
        logic out_free;
        logic cnt_done;
    } t_sts;

    // reverse lookup of a line byte; control codes and non-codes give ok = 0
    function automatic t_decode decode(input logic [BYTE_W-1:0] raw);
        t_decode d;
        d.ok    = 1'b0;
        d.value = '0;
        for (int i = 0; i < CODE_N; i++) begin
            if (CODE_TABLE[i] == raw) begin
                d.ok    = 1'b1;
                d.value = VALUE_W'(i);
            end
        end
        return d;
    endfunction

endpackage

// File: design/rc48_in_if.sv
interface rc48_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/rc48_out_if.sv
interface rc48_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

// File: design/railcom_4of8_id0_decoder.sv
// a request is taken in IDLE, then the previous and the new byte are decoded
// in the OLD and NEW states; ready returns when the controller is back in IDLE.
// a completed payload adds HISTORY_DEPTH + 1 output bytes (17 by default),
// one result per cycle while the sink keeps ready high, through the output register.
// a new byte is not taken until the last one, and any dump it starts, is done.
// reset clears the history at once through per-slot written flags.
module railcom_4of8_id0_decoder #(
    parameter int HISTORY_DEPTH = rc48_pkg::HISTORY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rc48_in_if.sink           i_rx,
    rc48_out_if.source        o_res
);

    rc48_pkg::t_cmd cmd;
    rc48_pkg::t_sts sts;
    logic           in_ready;
    logic           out_valid;
    logic [7:0]     out_byte;
    logic           out_last;

    // control
    rc48_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    rc48_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx.rx_byte),
        .i_out_ready (o_res.ready),
        .o_out_valid (out_valid),
        .o_out_byte  (out_byte),
        .o_out_last  (out_last),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // channel hookup
    assign i_rx.ready     = in_ready;
    assign o_res.valid    = out_valid;
    assign o_res.out_byte = out_byte;
    assign o_res.last     = out_last;

endmodule

// File: design/rc48_ctrl.sv
module rc48_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rc48_pkg::t_sts i_sts,
    output rc48_pkg::t_cmd o_cmd
);

    rc48_pkg::t_state r_state;
    rc48_pkg::t_state n_state;
    logic             r_new_pending;
    logic             n_new_pending;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rc48_pkg::ST_IDLE;
            r_new_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_new_pending <= n_new_pending;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_new_pending = r_new_pending;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        case (r_state)
            rc48_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = rc48_pkg::ST_OLD;
                end
            end
            rc48_pkg::ST_OLD: begin
                // previous byte first
                o_cmd.handle = 1'b1;
                if (i_sts.dump_hit) begin
                    o_cmd.dump_start = 1'b1;
                    n_new_pending    = 1'b1;
                    n_state          = rc48_pkg::ST_DUMP;
                end else begin
                    n_state = rc48_pkg::ST_NEW;
                end
            end
            rc48_pkg::ST_NEW: begin
                o_cmd.handle  = 1'b1;
                o_cmd.sel_new = 1'b1;
                if (i_sts.dump_hit) begin
                    o_cmd.dump_start = 1'b1;
                    n_state          = rc48_pkg::ST_DUMP;
                end else begin
                    n_state = rc48_pkg::ST_IDLE;
                end
            end
            rc48_pkg::ST_DUMP: begin
                // one history byte per free output slot, then the payload
                if (i_sts.out_free) begin
                    if (i_sts.cnt_done) begin
                        o_cmd.load_last = 1'b1;
                        n_new_pending   = 1'b0;
                        n_state         = r_new_pending ? rc48_pkg::ST_NEW
                                                        : rc48_pkg::ST_IDLE;
                    end else begin
                        o_cmd.load_entry = 1'b1;
                    end
                end
            end
            default: begin
                n_state = rc48_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/rc48_datapath.sv
module rc48_datapath #(
    parameter int HISTORY_DEPTH = rc48_pkg::HISTORY_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last,
    input  rc48_pkg::t_cmd i_cmd,
    output rc48_pkg::t_sts o_sts
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DUMP_LEN  = CW'(HISTORY_DEPTH);

    logic [7:0]         r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_vld;
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      n_wp;
    logic [7:0]         r_prior_byte;
    logic [7:0]         r_older;
    logic               r_await;
    logic [7:0]         r_partial;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_rd_cnt;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic [7:0]         handle_raw;
    rc48_pkg::t_decode  dec;

    // ring advance
    assign n_wp = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;

    // byte under decode
    assign handle_raw = i_cmd.sel_new ? r_prior_byte : r_older;
    assign dec        = rc48_pkg::decode(handle_raw);

    // status to controller
    assign o_sts.dump_hit = r_await && dec.ok;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.cnt_done = (r_rd_cnt == DUMP_LEN);

    // history store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[n_wp] <= i_rx_byte;
        end
    end

    // written flags, ring position and byte pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_wp         <= '0;
            r_prior_byte <= '0;
        end else if (i_cmd.accept) begin
            r_vld[n_wp]  <= 1'b1;
            r_wp         <= n_wp;
            r_prior_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_older <= r_prior_byte;
        end
    end

    // id0 search and payload assembly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await   <= 1'b0;
            r_partial <= '0;
        end else if (i_cmd.handle) begin
            if (r_await) begin
                r_await <= 1'b0;
                if (dec.ok) begin
                    r_partial <= r_partial + {2'b00, dec.value};
                end
            end else if (dec.ok && ((dec.value & rc48_pkg::ID0_MASK) == '0)) begin
                r_partial <= {dec.value[1:0], 6'b000000};
                r_await   <= 1'b1;
            end
        end
    end

    // dump read pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_rd_cnt <= '0;
        end else if (i_cmd.dump_start) begin
            r_rd_ptr <= n_wp;
            r_rd_cnt <= '0;
        end else if (i_cmd.load_entry) begin
            r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            r_rd_cnt <= r_rd_cnt + 1'b1;
        end
    end

    // output register, also the registered read of the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_entry || i_cmd.load_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_entry) begin
            r_out_byte <= r_vld[r_rd_ptr] ? r_mem[r_rd_ptr] : 8'h00;
            r_out_last <= 1'b0;
        end else if (i_cmd.load_last) begin
            r_out_byte <= r_partial;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule
